// ----- hdl/lkvc_pkg.sv -----
// lkvc_pkg: shared types and constants for the lru key-value cache
// used by lkvc_ctrl, lkvc_dp and lru_key_value_cache; no dependencies
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(ENTRIES);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // register index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic capture;     // latch request and tag compare
    logic commit_set;  // apply set to the entry table
    logic load_out;    // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic op_set;      // latched request is a set
  } dp_status_t;

endpackage

// ----- hdl/lkvc_dp.sv -----
// lkvc_dp: entry table, tag compare, recency update and result register
// depends on lkvc_pkg
module lkvc_dp
  import lkvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic                     operation_i,
  input  logic signed [DATA_W-1:0] lookup_key_i,
  input  logic signed [DATA_W-1:0] store_value_i,
  input  logic [IDX_W-1:0]         cap_m1_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic                     hit_o
);

  logic                op_q;
  logic [DATA_W-1:0]   key_q;
  logic [DATA_W-1:0]   val_q;
  logic [ENTRIES-1:0]  match_q, match_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [DATA_W-1:0]   keys_q   [ENTRIES];
  logic [DATA_W-1:0]   values_q [ENTRIES];
  logic [IDX_W-1:0]    rank_q   [ENTRIES];
  logic [DATA_W-1:0]   read_value_q;
  logic                hit_q;

  logic                hit;
  logic [IDX_W-1:0]    hit_slot;
  logic [IDX_W-1:0]    hit_rank;
  logic [ENTRIES-1:0]  keep;
  logic [IDX_W-1:0]    free_slot;

  // tag compare straight off the request ports
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = valid_q[i] && (keys_q[i] == $unsigned(lookup_key_i));
    end
  end

  always_comb begin
    hit      = |match_q;
    hit_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) hit_slot = IDX_W'(i);
    end
    hit_rank = rank_q[hit_slot];
  end

  // entries at or past the capacity edge drop out on an insert
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      keep[i] = valid_q[i] && (rank_q[i] < cap_m1_i);
    end
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!keep[i]) free_slot = IDX_W'(i);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit_set && !hit) begin
      valid_d = keep;
      valid_d[free_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      match_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.capture) match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      key_q <= $unsigned(lookup_key_i);
      val_q <= $unsigned(store_value_i);
    end
    if (cmd_i.commit_set) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit) begin
          if (match_q[i]) begin
            values_q[i] <= val_q;
            rank_q[i]   <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end else begin
          if (IDX_W'(i) == free_slot) begin
            keys_q[i]   <= key_q;
            values_q[i] <= val_q;
            rank_q[i]   <= '0;
          end else if (keep[i]) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
      end
    end
    if (cmd_i.load_out) begin
      read_value_q <= hit ? values_q[hit_slot] : MISS_VALUE;
      hit_q        <= hit;
    end
  end

  assign status_o.op_set = (op_q == OP_SET);
  assign read_value_o    = $signed(read_value_q);
  assign hit_o           = hit_q;

  // stored keys are distinct, so at most one entry matches
  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_set |-> $onehot0(match_q))
    else $error("multiple entries match one key");

  // a set always leaves at least one live entry
  a_set_leaves_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_set |=> (valid_q != '0))
    else $error("entry table empty after set");

  // an insert never takes a slot that stays live
  a_free_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit_set && !hit) |-> !keep[free_slot])
    else $error("insert slot still occupied");

endmodule

// ----- hdl/lkvc_ctrl.sv -----
// lkvc_ctrl: request sequencer and result valid flag
// depends on lkvc_pkg
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (status_i.op_set) begin
          cmd_o.commit_set = 1'b1;
          state_d          = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // a get waits while the result register is still full
  a_get_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && !status_i.op_set && out_valid_q && !out_ready_i)
      |=> (state_q == S_UPDATE))
    else $error("get left update with result register full");

  // a loaded result shows up as valid next cycle
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load lost");

  // commands are mutually exclusive
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.commit_set, cmd_o.load_out}))
    else $error("overlapping datapath commands");

endmodule

// ----- hdl/lru_key_value_cache.sv -----
// lru_key_value_cache: fully associative key-value store, least-recently-set replacement
// depends on lkvc_pkg, lkvc_ctrl, lkvc_dp
//
//   channel   handshake                 payload
//   request   in_valid_i / in_ready_o   operation_i, lookup_key_i, store_value_i
//   result    out_valid_o / out_ready_i read_value_o, hit_o (one beat per get)
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata (capacity at 0x0)
//
// each request beat is accepted in S_IDLE, which runs the 16-way tag compare; S_UPDATE
// then applies the set or loads the result register, and no new beat is taken until S_IDLE
// a get stalls in S_UPDATE while the result register still holds
// an untaken beat; a set never stalls
// reset empties the table at once (valid bits) and sets capacity to 16
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic signed [DATA_W-1:0] lookup_key_i,
  input  logic signed [DATA_W-1:0] store_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic                     hit_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [CAP_W-1:0] cap_q;
  logic [IDX_W-1:0] cap_m1;
  logic             cap_wr;

  // apb register: capacity, written in the access phase
  assign pready = 1'b1;
  assign cap_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cap_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_q} : '0;

  // active capacity minus one: zero acts as one, large values saturate
  always_comb begin
    if (cap_q == '0) begin
      cap_m1 = '0;
    end else if (32'(cap_q) > ENTRIES) begin
      cap_m1 = IDX_W'(ENTRIES - 1);
    end else begin
      cap_m1 = IDX_W'(cap_q - 1'b1);
    end
  end

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lkvc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (operation_i),
    .lookup_key_i  (lookup_key_i),
    .store_value_i (store_value_i),
    .cap_m1_i      (cap_m1),
    .read_value_o  (read_value_o),
    .hit_o         (hit_o)
  );

endmodule

// ----- tb/lkvc_checker.sv -----
`timescale 1ns / 100ps
// lkvc_checker: watches the request, result and config ports of the lru key-value cache,
// predicts each get result and compares it; depends on lkvc_pkg only
module lkvc_checker
  import lkvc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic              req_op_i,
  input  logic [DATA_W-1:0] req_key_i,
  input  logic [DATA_W-1:0] req_value_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  logic [DATA_W-1:0] rsp_value_i,
  input  logic              rsp_hit_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  output int                mismatch_count_o,
  output int                req_beats_o,
  output int                pending_o,
  output int                hit_beats_o,
  output int                cap_writes_o
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              hit;
  } lookup_result_t;

  lookup_result_t    pending_lookups[$];

  // shadow copy of the entry table
  logic [DATA_W-1:0] cache_keys[ENTRIES];
  logic [DATA_W-1:0] cache_vals[ENTRIES];
  logic              cache_live[ENTRIES];
  int                age_rank[ENTRIES];
  int                live_count;
  logic [CAP_W-1:0]  cap_reg;

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    mismatch_count_o++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic int lookup_slot(logic [DATA_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (cache_live[i] && cache_keys[i] == key) return i;
    return -1;
  endfunction

  // zero behaves as one, anything above the table size saturates
  function automatic int effective_capacity();
    int c;
    c = int'(cap_reg);
    if (c == 0) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  function automatic bit drop_least_recent();
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_live[i] && age_rank[i] + 1 == live_count) begin
        cache_live[i] = 1'b0;
        age_rank[i]   = 0;
        live_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void promote_entry(int slot);
    int r;
    r = age_rank[slot];
    for (int i = 0; i < ENTRIES; i++)
      if (cache_live[i] && age_rank[i] < r) age_rank[i]++;
    age_rank[slot] = 0;
  endfunction

  function automatic void apply_set(logic [DATA_W-1:0] key, logic [DATA_W-1:0] val);
    int slot;
    slot = lookup_slot(key);
    if (slot >= 0) begin
      cache_vals[slot] = val;
      promote_entry(slot);
      return;
    end
    // a lowered capacity may need several evictions here
    while (live_count > 0 && live_count >= effective_capacity())
      if (!drop_least_recent()) break;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (!cache_live[i] && slot < 0) slot = i;
    if (slot < 0) return;
    for (int i = 0; i < ENTRIES; i++)
      if (cache_live[i]) age_rank[i]++;
    cache_keys[slot] = key;
    cache_vals[slot] = val;
    cache_live[slot] = 1'b1;
    age_rank[slot]   = 0;
    live_count++;
  endfunction

  function automatic lookup_result_t predict_get(logic [DATA_W-1:0] key);
    lookup_result_t res;
    int slot;
    slot = lookup_slot(key);
    if (slot >= 0) begin
      res.value = cache_vals[slot];
      res.hit   = 1'b1;
    end else begin
      res.value = MISS_VALUE;
      res.hit   = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cache_keys[i] = '0;
        cache_vals[i] = '0;
        cache_live[i] = 1'b0;
        age_rank[i]   = 0;
      end
      live_count = 0;
      cap_reg    = CAP_RESET;
      pending_lookups.delete();
      pending_o  = 0;
    end else begin
      // results first: a result always belongs to an earlier request beat
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_lookups.size() == 0) begin
          report_mismatch("result with none expected", rsp_value_i, '0);
        end else begin
          want = pending_lookups.pop_front();
          if (rsp_value_i !== want.value)
            report_mismatch("read_value", rsp_value_i, want.value);
          if (rsp_hit_i !== want.hit)
            report_mismatch("hit", DATA_W'(rsp_hit_i), DATA_W'(want.hit));
          if (want.hit) hit_beats_o++;
        end
      end
      if (req_valid_i && req_ready_i) begin
        req_beats_o++;
        if (req_op_i == OP_GET) pending_lookups.push_back(predict_get(req_key_i));
        else apply_set(req_key_i, req_value_i);
      end
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_CAPACITY) begin
        if (pwrite_i) begin
          cap_reg = pwdata_i[CAP_W-1:0];
          cap_writes_o++;
        end else if (prdata_i[CAP_W-1:0] !== cap_reg) begin
          report_mismatch("capacity readback", DATA_W'(prdata_i[CAP_W-1:0]),
                          DATA_W'(cap_reg));
        end
      end
      pending_o = pending_lookups.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for lru_key_value_cache, with lkvc_checker doing the
// prediction and comparison; depends on lkvc_pkg, lkvc_checker and the cache rtl
module tb_top;
  import lkvc_pkg::*;

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 152;
  localparam int HOLD_CYCLES  = 250;     // long result-side hold-off
  localparam int DRAIN_CYCLES = 4;       // a set can still be in flight with no result due
  localparam int CYCLE_LIMIT  = 400_000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               operation_i;
  logic [DATA_W-1:0]  lookup_key_i;
  logic [DATA_W-1:0]  store_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [DATA_W-1:0]  read_value_o;
  logic               hit_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int beats_in;
  int lookups_pending;
  int hit_count;
  int cap_writes;
  int items_sent;
  int cycle_count;

  // knobs shared by the stimulus and the result-side driver
  logic sender_gaps;
  logic ready_gaps;
  logic hold_req;
  int   stall_left;

  logic [DATA_W-1:0] key_pool[$];

  lru_key_value_cache u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .lookup_key_i  (lookup_key_i),
    .store_value_i (store_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .hit_o         (hit_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lkvc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_ready_i      (in_ready_o),
    .req_op_i         (operation_i),
    .req_key_i        (lookup_key_i),
    .req_value_i      (store_value_i),
    .rsp_valid_i      (out_valid_o),
    .rsp_ready_i      (out_ready_i),
    .rsp_value_i      (read_value_o),
    .rsp_hit_i        (hit_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .mismatch_count_o (mismatches),
    .req_beats_o      (beats_in),
    .pending_o        (lookups_pending),
    .hit_beats_o      (hit_count),
    .cap_writes_o     (cap_writes)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lookups outstanding", cycle_count,
               lookups_pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result-side ready: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // counted here so the sender keeps offering beats and the cache backs up
        out_ready_i <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (ready_gaps && stall_left == 0 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 19);
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // one request beat; entered and left at a falling edge, returns once accepted
  task automatic send_item(input logic op, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] val);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    lookup_key_i  <= key;
    store_value_i <= val;
    items_sent++;
    // the checker counts accepted beats at the rising edge
    do @(negedge clk_i); while (beats_in != items_sent);
  endtask

  // drop valid and wait for every outstanding result, then let a trailing set finish
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (lookups_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // capacity write followed by a readback; upper data bits carry noise
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [31:0] word;
    word = $urandom();
    word[CAP_W-1:0] = cap;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // small key pool per phase so hits, updates and evictions all happen often
  task automatic build_key_pool();
    int n;
    logic [DATA_W-1:0] k;
    n = $urandom_range(2, 22);
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       k = 32'h8000_0000;
        1:       k = 32'h7fff_ffff;
        2:       k = '1;
        3:       k = '0;
        default: k = $urandom();
      endcase
      key_pool.push_back(k);
    end
  endtask

  task automatic send_random_item();
    logic              op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
    op = ($urandom_range(0, 1) == 1) ? OP_SET : OP_GET;
    // mostly pool keys; the rest are fresh keys that nearly always miss
    if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else key = $urandom();
    case ($urandom_range(0, 15))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      2:       val = '1;
      3:       val = '0;
      default: val = $urandom();
    endcase
    send_item(op, key, val);
  endtask

  initial begin
    int phase_cap[NUM_PHASES];
    int cap;

    // every input known from time zero
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = OP_GET;
    lookup_key_i  = '0;
    store_value_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sender_gaps   = 1'b1;
    ready_gaps    = 1'b1;
    hold_req      = 1'b0;
    items_sent    = 0;
    cycle_count   = 0;

    // first phase lowers capacity under a full table; -1 picks a random setting
    phase_cap = '{3, 0, 1, 31, 17, 2, 16, 8, -1, 5, -1, 16};

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset capacity of 16
    // empty table: key zero and all-ones key must both miss
    send_item(OP_GET, '0, $urandom());
    send_item(OP_GET, '1, $urandom());
    // extreme keys and values
    send_item(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_SET, '0, '0);
    send_item(OP_SET, '1, '1);
    send_item(OP_GET, 32'h8000_0000, $urandom());
    // stored all-ones value is told apart from a miss only by hit
    send_item(OP_GET, '1, $urandom());
    send_item(OP_GET, '0, $urandom());
    // update of a present key moves it to the front without evicting
    send_item(OP_SET, 32'h8000_0000, $urandom());
    send_item(OP_GET, 32'h8000_0000, $urandom());
    // fill the table to 16 entries
    for (int k = 1; k <= 12; k++) send_item(OP_SET, DATA_W'(k), $urandom());
    // a new key on a full table evicts the oldest set, 7fffffff
    send_item(OP_SET, 32'h0000_0100, $urandom());
    send_item(OP_GET, 32'h7fff_ffff, $urandom());
    send_item(OP_GET, 32'h8000_0000, $urandom());

    // random phases, each at its own capacity
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      cap = (phase_cap[ph] < 0) ? $urandom_range(0, 31) : phase_cap[ph];
      set_capacity(CAP_W'(cap));
      build_key_pool();
      // some phases run without gaps; the closing phase never idles
      sender_gaps = (ph % 4 != 2) && (ph != NUM_PHASES - 1);
      ready_gaps  = sender_gaps;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_req = 1'b1;
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          // sender pause until the result side has caught up
          in_valid_i <= 1'b0;
          do @(negedge clk_i); while (lookups_pending != 0);
        end
        send_random_item();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d request beats with %0d hits over %0d capacity writes",
             beats_in, hit_count, cap_writes);
    $display("capacities went through zero, one, full, above range and below occupancy");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
